FILE: design/lsp_pkg.sv
package lsp_pkg;

    // Default data format: signed Q16.16 values.
    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Augmented matrix shape.
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 5;

    // Operation a row cell performs in the current cycle.
    typedef enum logic [3:0] {
        CELL_IDLE   = 4'd0,
        CELL_LOAD   = 4'd1,
        CELL_COPY   = 4'd2,
        CELL_SWAP   = 4'd3,
        CELL_WRITE  = 4'd4,
        CELL_FLATCH = 4'd5,
        CELL_MINIT  = 4'd6,
        CELL_MSTEP  = 4'd7,
        CELL_MTERM  = 4'd8,
        CELL_MAPPLY = 4'd9
    } cell_op_t;

    // Control handed from the sequencer to one row cell.
    typedef struct packed {
        cell_op_t   op;
        logic [1:0] col;
        logic [2:0] elem;
    } cell_ctl_t;

    // Pivot search token passed down the chain of cells.
    typedef struct packed {
        logic [1:0] best;
        logic [1:0] cur;
    } srch_t;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MODE      = 1'b1;

endpackage

FILE: design/lsp_div.sv
module lsp_div #(
    parameter int WORK_BITS     = 48,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORK_BITS-1:0] numer,
    input  logic [WORK_BITS-1:0] denom,
    output logic                 done,
    output logic [WORK_BITS-1:0] quot
);

    localparam int W   = WORK_BITS;
    localparam int N   = WORK_BITS + FRACTION_BITS;
    localparam int CW  = $clog2(N + 1);
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic          run_reg, fin_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [N-1:0]  num_reg, q_reg;
    logic [W:0]    rem_reg;
    logic [W-1:0]  up_reg, quot_reg;
    logic          neg_reg;

    logic [W-1:0]  numer_mag, denom_mag;
    logic [W:0]    rem_sh, rem_sub;
    logic          take;
    logic [W+1:0]  rem_dbl;
    logic          rnd;
    logic [N:0]    q_rnd;
    logic          over;

    // Magnitudes of the operands; the most negative value maps to its true magnitude.
    assign numer_mag = numer[W-1] ? (~numer + W'(1)) : numer;
    assign denom_mag = denom[W-1] ? (~denom + W'(1)) : denom;

    // One restoring step: bring down the next numerator bit and try a subtract.
    assign rem_sh  = {rem_reg[W-1:0], num_reg[N-1]};
    assign take    = rem_sh >= {1'b0, up_reg};
    assign rem_sub = rem_sh - {1'b0, up_reg};

    // Round to nearest, ties away from zero, then saturate to the work width.
    assign rem_dbl = {rem_reg, 1'b0};
    assign rnd     = rem_dbl >= {2'b00, up_reg};
    assign q_rnd   = {1'b0, q_reg} + (N+1)'(rnd);
    assign over    = |q_rnd[N:W-1];

    // Control flags of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(N - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {numer_mag, {FRACTION_BITS{1'b0}}};
            up_reg  <= denom_mag;
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= numer[W-1] ^ denom[W-1];
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[N-2:0], 1'b0};
            rem_reg <= take ? rem_sub : rem_sh;
            q_reg   <= {q_reg[N-2:0], take};
        end
        if (fin_reg)
        begin
            if (over)
                quot_reg <= neg_reg ? WMIN : WMAX;
            else if (neg_reg)
                quot_reg <= ~{1'b0, q_rnd[W-2:0]} + W'(1);
            else
                quot_reg <= {1'b0, q_rnd[W-2:0]};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: design/lsp_cell.sv
module lsp_cell #(
    parameter int WORK_BITS     = 48,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lsp_pkg::cell_ctl_t        ctl,
    input  logic [4:0][WORK_BITS-1:0] row_in,
    input  logic [WORK_BITS-1:0]      wr_value,
    input  logic [WORK_BITS-1:0]      bcast,
    input  logic [WORK_BITS-1:0]      sin_mag,
    input  lsp_pkg::srch_t            sin,
    output logic [WORK_BITS-1:0]      sout_mag,
    output lsp_pkg::srch_t            sout,
    output logic [4:0][WORK_BITS-1:0] row_out
);

    localparam int W = WORK_BITS;
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic [4:0][W-1:0] store_reg, work_reg;
    logic [W-1:0]      f_reg, mb_reg, term_reg;
    logic [2*W-1:0]    ma_reg, acc_reg;
    logic              neg_reg;
    logic [W-1:0]      smag_reg;
    lsp_pkg::srch_t    s_reg;

    logic [W-1:0]      own, own_mag, f_mag, b_mag;
    logic              better;
    logic              over;
    logic [W-2:0]      q;
    logic [W-1:0]      term_next;
    logic [W-1:0]      a_elem;
    logic [W:0]        diff;
    logic [W-1:0]      apply_next;

    // Pivot search stage: keep the larger magnitude, first row on ties.
    assign own     = work_reg[{1'b0, ctl.col}];
    assign own_mag = own[W-1] ? (~own + W'(1)) : own;
    assign better  = (sin.cur >= ctl.col) && (own_mag > sin_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else
        begin
            s_reg.cur  <= sin.cur + 2'd1;
            s_reg.best <= better ? sin.cur : sin.best;
        end
    end

    always_ff @(posedge clk)
    begin
        smag_reg <= better ? own_mag : sin_mag;
    end

    // Operand magnitudes for the shift-add multiplier.
    assign f_mag = f_reg[W-1] ? (~f_reg + W'(1)) : f_reg;
    assign b_mag = bcast[W-1] ? (~bcast + W'(1)) : bcast;

    // Rounded product term, saturated to the work width.
    assign over = |acc_reg[2*W-1:FRACTION_BITS+W-1];
    assign q    = acc_reg[FRACTION_BITS+W-2:FRACTION_BITS];
    always_comb
    begin
        if (over)
            term_next = neg_reg ? WMIN : WMAX;
        else if (neg_reg)
            term_next = ~{1'b0, q} + W'(1);
        else
            term_next = {1'b0, q};
    end

    // Saturating subtract of the term from the selected element.
    assign a_elem = work_reg[ctl.elem];
    assign diff   = {a_elem[W-1], a_elem} - {term_reg[W-1], term_reg};
    always_comb
    begin
        if (diff[W] != diff[W-1])
            apply_next = diff[W] ? WMIN : WMAX;
        else
            apply_next = diff[W-1:0];
    end

    // Row storage and multiplier datapath.
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            lsp_pkg::CELL_LOAD:   store_reg <= row_in;
            lsp_pkg::CELL_COPY:   work_reg <= store_reg;
            lsp_pkg::CELL_SWAP:   work_reg <= row_in;
            lsp_pkg::CELL_WRITE:  work_reg[ctl.elem] <= wr_value;
            lsp_pkg::CELL_FLATCH: f_reg <= own;
            lsp_pkg::CELL_MINIT:
            begin
                ma_reg  <= {{W{1'b0}}, f_mag};
                mb_reg  <= b_mag;
                acc_reg <= (2*W)'(1) << (FRACTION_BITS - 1);
                neg_reg <= f_reg[W-1] ^ bcast[W-1];
            end
            lsp_pkg::CELL_MSTEP:
            begin
                if (mb_reg[0])
                    acc_reg <= acc_reg + ma_reg;
                ma_reg <= {ma_reg[2*W-2:0], 1'b0};
                mb_reg <= {1'b0, mb_reg[W-1:1]};
            end
            lsp_pkg::CELL_MTERM:  term_reg <= term_next;
            lsp_pkg::CELL_MAPPLY: work_reg[ctl.elem] <= apply_next;
            default:
            begin
            end
        endcase
    end

    assign sout_mag = smag_reg;
    assign sout     = s_reg;
    assign row_out  = work_reg;

endmodule

FILE: design/linear_solve_4x4_pivoting.sv
// A solve starts when row 3 is loaded; it runs on a bit-serial divider and bit-serial
// multipliers in the row cells at work width W = min(VALUE_WIDTH+16, 63), 48 at Q16.16.
// Loads of rows 0 to 2 leave busy low; a solve keeps busy high until its last result is
// registered, and that result is on the ports in the first cycle with busy low.
// Results leave one per cycle with a strobe; the receiver cannot stall.
// Reset clears control and configuration; matrix storage is undefined until loaded.
module linear_solve_4x4_pivoting #(
    parameter int VALUE_WIDTH   = lsp_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = lsp_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [30:0]                   cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    row_index,
    input  logic signed [VALUE_WIDTH-1:0] coef_col0,
    input  logic signed [VALUE_WIDTH-1:0] coef_col1,
    input  logic signed [VALUE_WIDTH-1:0] coef_col2,
    input  logic signed [VALUE_WIDTH-1:0] coef_col3,
    input  logic signed [VALUE_WIDTH-1:0] rhs_value,
    output logic                          result_strobe,
    output logic [1:0]                    component_index,
    output logic signed [VALUE_WIDTH-1:0] solution_value,
    output logic                          solved,
    output logic                          last_result
);

    localparam int W   = (VALUE_WIDTH + 16 > 63) ? 63 : VALUE_WIDTH + 16;
    localparam int VW  = VALUE_WIDTH;
    localparam int EW  = ((VW > W) ? VW : W) + 1;
    localparam int TW  = W + FRACTION_BITS + 32;
    localparam int CW  = $clog2(W + 1);
    localparam int SH_UP = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
    localparam int SH_DN = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam logic signed [EW-1:0] WMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;
    localparam logic signed [EW-1:0] VMAX_E = {{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_COPY      = 13'b0000000000010,
        S_SEARCH    = 13'b0000000000100,
        S_CHECK     = 13'b0000000001000,
        S_DIV_START = 13'b0000000010000,
        S_DIV_WAIT  = 13'b0000000100000,
        S_F_LATCH   = 13'b0000001000000,
        S_M_INIT    = 13'b0000010000000,
        S_M_STEP    = 13'b0000100000000,
        S_M_TERM    = 13'b0001000000000,
        S_M_APPLY   = 13'b0010000000000,
        S_EMIT      = 13'b0100000000000,
        S_FAIL      = 13'b1000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    col_reg, col_next;
    logic [2:0]    elem_reg, elem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  piv_reg;
    logic [30:0]   thr_reg;
    logic          mode_reg;

    logic                 strobe_reg, solved_reg, last_reg;
    logic [1:0]           idx_reg;
    logic [VW-1:0]        sol_reg;

    lsp_pkg::cell_ctl_t   ctl     [4];
    logic [4:0][W-1:0]    row_in  [4];
    logic [4:0][W-1:0]    rows    [4];
    logic [W-1:0]         smag    [5];
    lsp_pkg::srch_t       srch    [5];
    logic [4:0][W-1:0]    load_row;
    logic signed [VW-1:0] fields  [5];
    logic signed [EW-1:0] ext;
    logic signed [EW-1:0] oext;
    logic [VW-1:0]        emit_val;

    logic          div_start, div_done;
    logic [W-1:0]  div_numer, div_denom, div_quot;
    logic [W-1:0]  bcast;
    logic [W-1:0]  best_mag;
    logic [1:0]    best;
    logic [TW-1:0] thr_scaled;
    logic          pivot_fail;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lsp_pkg::CFG_THRESHOLD: thr_reg <= cfg_data;
                lsp_pkg::CFG_MODE:      mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input fields saturated into the work format.
    assign fields[0] = coef_col0;
    assign fields[1] = coef_col1;
    assign fields[2] = coef_col2;
    assign fields[3] = coef_col3;
    assign fields[4] = rhs_value;

    always_comb
    begin
        load_row = '0;
        ext      = '0;
        for (int k = 0; k < 5; k++)
        begin
            ext = EW'(fields[k]);
            if (ext > WMAX_E)
                load_row[k] = WMAX_E[W-1:0];
            else if (ext < WMIN_E)
                load_row[k] = WMIN_E[W-1:0];
            else
                load_row[k] = ext[W-1:0];
        end
    end

    // Pivot fails if zero, or in mode 1 if below the threshold rescaled, rounded up.
    assign best_mag   = smag[4];
    assign best       = srch[4].best;
    assign thr_scaled = ((TW'(thr_reg) + (TW'(1) << SH_DN) - TW'(1)) >> SH_DN) << SH_UP;
    assign pivot_fail = (best_mag == '0) || (mode_reg && (TW'(best_mag) < thr_scaled));

    // Head of the search chain.
    assign smag[0]      = '0;
    assign srch[0].best = col_reg;
    assign srch[0].cur  = 2'd0;

    // Operands for the divider and the multiplier broadcast.
    assign div_start = (state_reg == S_DIV_START);
    assign div_numer = rows[col_reg][elem_reg];
    assign div_denom = (elem_reg == 3'd0) ? rows[col_reg][{1'b0, col_reg}] : piv_reg;
    assign bcast     = rows[col_reg][elem_reg];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        elem_next  = elem_reg;
        cnt_next   = cnt_reg;
        for (int r = 0; r < 4; r++)
        begin
            ctl[r].op   = lsp_pkg::CELL_IDLE;
            ctl[r].col  = col_reg;
            ctl[r].elem = elem_reg;
            row_in[r]   = load_row;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl[row_index].op = lsp_pkg::CELL_LOAD;
                    if (row_index == 2'd3)
                        state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                for (int r = 0; r < 4; r++)
                    ctl[r].op = lsp_pkg::CELL_COPY;
                col_next   = 2'd0;
                cnt_next   = '0;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(4))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (pivot_fail)
                    state_next = S_FAIL;
                else
                begin
                    ctl[col_reg].op = lsp_pkg::CELL_SWAP;
                    row_in[col_reg] = rows[best];
                    ctl[best].op    = lsp_pkg::CELL_SWAP;
                    row_in[best]    = rows[col_reg];
                    elem_next       = 3'd0;
                    state_next      = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    ctl[col_reg].op = lsp_pkg::CELL_WRITE;
                    if (elem_reg == 3'd4)
                    begin
                        elem_next  = 3'd0;
                        state_next = S_F_LATCH;
                    end
                    else
                    begin
                        elem_next  = elem_reg + 3'd1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_F_LATCH:
            begin
                for (int r = 0; r < 4; r++)
                    if (r[1:0] != col_reg)
                        ctl[r].op = lsp_pkg::CELL_FLATCH;
                state_next = S_M_INIT;
            end
            S_M_INIT:
            begin
                for (int r = 0; r < 4; r++)
                    if (r[1:0] != col_reg)
                        ctl[r].op = lsp_pkg::CELL_MINIT;
                cnt_next   = '0;
                state_next = S_M_STEP;
            end
            S_M_STEP:
            begin
                for (int r = 0; r < 4; r++)
                    if (r[1:0] != col_reg)
                        ctl[r].op = lsp_pkg::CELL_MSTEP;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                    state_next = S_M_TERM;
            end
            S_M_TERM:
            begin
                for (int r = 0; r < 4; r++)
                    if (r[1:0] != col_reg)
                        ctl[r].op = lsp_pkg::CELL_MTERM;
                state_next = S_M_APPLY;
            end
            S_M_APPLY:
            begin
                for (int r = 0; r < 4; r++)
                    if (r[1:0] != col_reg)
                        ctl[r].op = lsp_pkg::CELL_MAPPLY;
                if (elem_reg == 3'd4)
                begin
                    elem_next = 3'd0;
                    cnt_next  = '0;
                    if (col_reg == 2'd3)
                        state_next = S_EMIT;
                    else
                    begin
                        col_next   = col_reg + 2'd1;
                        state_next = S_SEARCH;
                    end
                end
                else
                begin
                    elem_next  = elem_reg + 3'd1;
                    state_next = S_M_INIT;
                end
            end
            S_EMIT:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg[1:0] == 2'd3)
                    state_next = S_IDLE;
            end
            S_FAIL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            elem_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            elem_reg  <= elem_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The pivot is held for the whole normalization of its row.
    always_ff @(posedge clk)
    begin
        if (div_start && (elem_reg == 3'd0))
            piv_reg <= div_denom;
    end

    // Solution component saturated to the value width.
    always_comb
    begin
        oext = EW'($signed(rows[cnt_reg[1:0]][4]));
        if (oext > VMAX_E)
            emit_val = VMAX_E[VW-1:0];
        else if (oext < VMIN_E)
            emit_val = VMIN_E[VW-1:0];
        else
            emit_val = oext[VW-1:0];
    end

    // Result registers: one transfer per cycle while emitting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= (state_reg == S_EMIT) || (state_reg == S_FAIL);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT)
        begin
            idx_reg    <= cnt_reg[1:0];
            sol_reg    <= emit_val;
            solved_reg <= 1'b1;
            last_reg   <= (cnt_reg[1:0] == 2'd3);
        end
        else if (state_reg == S_FAIL)
        begin
            idx_reg    <= 2'd0;
            sol_reg    <= '0;
            solved_reg <= 1'b0;
            last_reg   <= 1'b1;
        end
    end

    // Shared divider for row normalization.
    lsp_div #(
        .WORK_BITS     (W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Chain of row cells.
    for (genvar g = 0; g < 4; g++)
    begin : g_cell
        lsp_cell #(
            .WORK_BITS     (W),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[g]),
            .row_in   (row_in[g]),
            .wr_value (div_quot),
            .bcast    (bcast),
            .sin_mag  (smag[g]),
            .sin      (srch[g]),
            .sout_mag (smag[g+1]),
            .sout     (srch[g+1]),
            .row_out  (rows[g])
        );
    end

    assign busy            = (state_reg != S_IDLE);
    assign result_strobe   = strobe_reg;
    assign component_index = idx_reg;
    assign solution_value  = sol_reg;
    assign solved          = solved_reg;
    assign last_result     = last_reg;

endmodule

FILE: tb/sv/tb_linear_solve_4x4_pivoting.sv
module tb_linear_solve_4x4_pivoting;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  VW     = 32;
    localparam int  FB     = 16;
    localparam int  WB     = 48;
    localparam longint WMAX = (longint'(1) <<< (WB - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;
    // Idle cycles waited after all loads and results are through, with margin.
    localparam int  DRAIN  = 3000;

    typedef struct {
        logic [1:0]           row;
        logic [4:0][VW-1:0]   val;
    } row_load_t;

    typedef struct {
        logic [1:0]    idx;
        logic [VW-1:0] value;
        logic          ok;
        logic          last;
    } component_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [30:0]       cfg_data;
    logic              start;
    logic              busy;
    logic [1:0]        row_index;
    logic signed [VW-1:0] coef_col0, coef_col1, coef_col2, coef_col3, rhs_value;
    logic              result_strobe;
    logic [1:0]        component_index;
    logic signed [VW-1:0] solution_value;
    logic              solved;
    logic              last_result;

    row_load_t  pending_loads[$];
    component_t expected_components[$];
    row_load_t  drv_load;
    longint     matrix_copy[20];
    logic [30:0] thr_copy;
    logic        mode_copy;
    int          sender_idle_pct;
    int          mismatches;

    linear_solve_4x4_pivoting u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy), .row_index(row_index),
        .coef_col0(coef_col0), .coef_col1(coef_col1), .coef_col2(coef_col2),
        .coef_col3(coef_col3), .rhs_value(rhs_value),
        .result_strobe(result_strobe), .component_index(component_index),
        .solution_value(solution_value), .solved(solved), .last_result(last_result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Fixed-point helpers at the working width.
    function automatic logic [127:0] magnitude(longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    function automatic longint clamp_work(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint sat_work(bit neg, logic [127:0] m);
        if (m >= (128'd1 << (WB - 1))) return neg ? WMIN : WMAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        logic [127:0] pr;
        pr = magnitude(a) * magnitude(b) + (128'd1 << (FB - 1));
        return sat_work((a < 0) != (b < 0), pr >> FB);
    endfunction

    function automatic longint fix_div(longint a, longint p);
        logic [127:0] num, den, q, rem;
        num = magnitude(a) << FB;
        den = magnitude(p);
        q   = num / den;
        rem = num % den;
        if (rem * 2 >= den) q = q + 1;
        return sat_work((a < 0) != (p < 0), q);
    endfunction

    // Gauss-Jordan solve on a copy of the loaded rows; queues the expected components.
    task automatic solve_and_expect();
        longint a[4][5];
        longint t, f, p;
        logic [127:0] bm, d;
        int best;
        bit fail;
        component_t cmp;
        fail = 0;
        for (int r = 0; r < 4; r++)
            for (int j = 0; j < 5; j++)
                a[r][j] = matrix_copy[r*5 + j];
        for (int c = 0; c < 4 && !fail; c++) begin
            bm = 0;
            best = c;
            for (int r = c; r < 4; r++) begin
                d = magnitude(a[r][c]);
                if (d > bm) begin
                    bm = d;
                    best = r;
                end
            end
            if (bm == 0 || (mode_copy && bm < 128'(thr_copy))) fail = 1;
            else begin
                for (int j = 0; j < 5; j++) begin
                    t = a[c][j];
                    a[c][j] = a[best][j];
                    a[best][j] = t;
                end
                p = a[c][c];
                for (int j = 0; j < 5; j++) a[c][j] = fix_div(a[c][j], p);
                for (int r = 0; r < 4; r++) begin
                    if (r != c) begin
                        f = a[r][c];
                        for (int j = 0; j < 5; j++)
                            a[r][j] = clamp_work(a[r][j] - fix_mul(f, a[c][j]));
                    end
                end
            end
        end
        if (fail) begin
            cmp = '{idx: 2'd0, value: '0, ok: 1'b0, last: 1'b1};
            expected_components.push_back(cmp);
        end else begin
            for (int r = 0; r < 4; r++) begin
                t = a[r][4];
                if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
                if (t < -64'sh80000000) t = -64'sh80000000;
                cmp = '{idx: 2'(r), value: t[VW-1:0], ok: 1'b1, last: (r == 3)};
                expected_components.push_back(cmp);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: one load transfer per start-and-not-busy edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                for (int j = 0; j < 5; j++)
                    matrix_copy[drv_load.row*5 + j] = longint'(signed'(drv_load.val[j]));
                if (drv_load.row == 2'd3) solve_and_expect();
            end
            if (!start || !busy)
            begin
                if (pending_loads.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    drv_load = pending_loads.pop_front();
                    start     <= 1'b1;
                    row_index <= drv_load.row;
                    coef_col0 <= drv_load.val[0];
                    coef_col1 <= drv_load.val[1];
                    coef_col2 <= drv_load.val[2];
                    coef_col3 <= drv_load.val[3];
                    rhs_value <= drv_load.val[4];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed component with the oldest expectation.
    always @(posedge clk)
    begin
        component_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_components.size() == 0)
            begin
                report_mismatch("unexpected component", 64'(solution_value), 64'd0);
            end
            else
            begin
                want = expected_components.pop_front();
                if (component_index !== want.idx)
                    report_mismatch("component_index", 64'(component_index), 64'(want.idx));
                if (solution_value !== want.value)
                    report_mismatch("solution_value", 64'(solution_value), 64'(want.value));
                if (solved !== want.ok)
                    report_mismatch("solved", 64'(solved), 64'(want.ok));
                if (last_result !== want.last)
                    report_mismatch("last_result", 64'(last_result), 64'(want.last));
            end
        end
    end

    function automatic logic [VW-1:0] rand_value();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4: return $urandom;
            default: return ($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF) ^ 32'($urandom_range(0, 32'h4_0000));
        endcase
    endfunction

    task automatic queue_load(logic [1:0] r, logic [VW-1:0] c0, logic [VW-1:0] c1,
                              logic [VW-1:0] c2, logic [VW-1:0] c3, logic [VW-1:0] b);
        row_load_t ld;
        ld.row = r;
        ld.val = {b, c3, c2, c1, c0};
        pending_loads.push_back(ld);
    endtask

    // One random system; mostly well-conditioned, some singular, noisy or reused.
    task automatic queue_system();
        logic [4:0][VW-1:0] v;
        logic [1:0] order[3];
        int style, dup, tmp, sw;
        style = $urandom_range(0, 99);
        order = '{2'd0, 2'd1, 2'd2};
        for (int i = 0; i < 3; i++) begin
            sw = $urandom_range(0, 2);
            tmp = order[i];
            order[i] = order[sw];
            order[sw] = 2'(tmp);
        end
        if (style < 12) begin
            // Only row 3 is reloaded; the other rows stay from before.
            queue_load(2'd3, rand_value(), rand_value(), rand_value(), rand_value(), rand_value());
            return;
        end
        dup = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
            logic [1:0] r;
            r = (i == 3) ? 2'd3 : order[i];
            for (int j = 0; j < 5; j++) begin
                if (style < 70)
                    v[j] = (j == r) ? (($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF)
                           ^ 32'($urandom_range(32'h4_0000, 32'h40_0000)))
                         : 32'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
                else
                    v[j] = rand_value();
            end
            if (style >= 70 && style < 80 && r == 2'd3) v[0] = '0;
            if (style >= 80 && style < 90 && r == 2'd3 && dup != 3) begin
                // Singular: row 3 repeats the matrix part of an earlier row.
                v[3:0] = pending_loads[pending_loads.size() - 3 + dup].val[3:0];
            end
            queue_load(r, v[0], v[1], v[2], v[3], v[4]);
            if (style >= 90 && i == 0)
                queue_load(r, rand_value(), rand_value(), rand_value(), rand_value(), rand_value());
        end
    endtask

    task automatic wait_idle();
        while (pending_loads.size() > 0 || start || busy || expected_components.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == lsp_pkg::CFG_THRESHOLD) thr_copy = data;
        else mode_copy = data[0];
    endtask

    initial
    begin
        logic [30:0] thresholds[6];
        logic        modes[6];
        mismatches = 0;
        sender_idle_pct = 10;
        thr_copy = '0;
        mode_copy = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = lsp_pkg::CFG_THRESHOLD;
        cfg_data = '0;
        start = 1'b0;
        row_index = '0;
        coef_col0 = '0; coef_col1 = '0; coef_col2 = '0; coef_col3 = '0; rhs_value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, extremes, zero pivot, swap needed, reused rows.
        queue_load(2'd0, 32'h1_0000, 0, 0, 0, 32'h7FFF_FFFF);
        queue_load(2'd1, 0, 32'h1_0000, 0, 0, 32'h8000_0000);
        queue_load(2'd2, 0, 0, 32'h1_0000, 0, 32'h0);
        queue_load(2'd3, 0, 0, 0, 32'h1_0000, 32'hFFFF_FFFF);
        queue_load(2'd3, 0, 0, 0, 0, 32'h1_0000);
        queue_load(2'd0, 0, 32'h2_0000, 0, 0, 32'h3_0000);
        queue_load(2'd1, 32'h2_0000, 0, 0, 0, 32'h1_0000);
        queue_load(2'd3, 0, 0, 0, 32'hFFFF_0000, 32'h5_0000);
        queue_load(2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_load(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0, 32'h8000_0000);
        queue_load(2'd2, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        queue_load(2'd3, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_load(2'd2, 0, 0, 0, 0, 0);
        queue_load(2'd3, 32'h0000_0001, 32'h1, 32'h1, 32'h1, 32'h1);
        queue_load(2'd0, 32'h1, 0, 0, 0, 32'h1_0000);
        queue_load(2'd1, 0, 32'h1, 0, 0, 32'h1_0000);
        queue_load(2'd2, 0, 0, 32'h1, 0, 32'h1_0000);
        queue_load(2'd3, 0, 0, 0, 32'h1, 32'h1_0000);
        wait_idle();

        // Phases through the register settings, extremes included.
        thresholds = '{31'h0, 31'h7FFF_FFFF, 31'h1_0000, 31'h0, 31'h2, 31'h0};
        modes      = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        thresholds[3] = 31'($urandom_range(0, 32'h8_0000));
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(lsp_pkg::CFG_THRESHOLD, thresholds[ph]);
            write_reg(lsp_pkg::CFG_MODE, 31'(modes[ph]));
            sender_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 56 : 0;
            for (int s = 0; s < 13; s++) queue_system();
            wait_idle();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
design/lsp_pkg.sv
design/lsp_div.sv
design/lsp_cell.sv
design/linear_solve_4x4_pivoting.sv
tb/sv/tb_linear_solve_4x4_pivoting.sv
